@@ hdl/fsbd_pkg.sv @@
// shared types and constants of the flux stream byte decoder
`default_nettype none
package fsbd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TS_W   = 24;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = VAL_W + 1;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SKIP_W = 16;
  localparam int unsigned PROD_W = SUM_W + TS_W;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [TS_W-1:0]   TIME_SCALE_RESET = 24'h010000;
  localparam logic [VAL_W-1:0]  OVFL_STEP        = 32'h0001_0000;

  localparam logic [BYTE_W-1:0] OP_CELL2_MAX = 8'h07;
  localparam logic [BYTE_W-1:0] OP_SKIP_BASE = 8'h08;
  localparam logic [BYTE_W-1:0] OP_SKIP_MAX  = 8'h0A;
  localparam logic [BYTE_W-1:0] OP_OVFL      = 8'h0B;
  localparam logic [BYTE_W-1:0] OP_CELL3     = 8'h0C;
  localparam logic [BYTE_W-1:0] OP_OOB       = 8'h0D;
  localparam logic [BYTE_W-1:0] TYPE_INDEX   = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_END     = 8'h0D;

  // register index within the config space
  localparam logic REG_TIME_SCALE = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_C2_LO    = 4'd1,
    PH_C3_HI    = 4'd2,
    PH_C3_LO    = 4'd3,
    PH_SKIP     = 4'd4,
    PH_OOB_TYPE = 4'd5,
    PH_SIZE_LO  = 4'd6,
    PH_SIZE_HI  = 4'd7,
    PH_PAY0     = 4'd8,
    PH_PAY1     = 4'd9,
    PH_PAY2     = 4'd10,
    PH_PAY3     = 4'd11,
    PH_PAYREST  = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_INDEX = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // decoded event before scaling; cells carry the 33 bit sum
  typedef struct packed {
    kind_t            kind;
    logic [SUM_W-1:0] val;
  } evt_t;

endpackage
`default_nettype wire

@@ hdl/flux_stream_byte_decoder_top.sv @@
// top level of the flux stream byte decoder
//
//  channel  signals                                   direction
//  in       in_valid/in_ready, stream_byte, first_byte  sink
//  out      out_valid/out_ready, event_kind, value     source
//  cfg      apb psel..prdata, time_scale at 0x0        slave
//
// one byte per cycle while the output is not stalled; every byte is decoded
// in the cycle it is taken; a result passes the parser register, then the
// 33x24 multiply and saturate into the result register
// rst_n synchronous, parser idle and time_scale 0x010000 after reset
// a stalled result holds; input keeps flowing until both registers are full
`default_nettype none
module flux_stream_byte_decoder_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fsbd_pkg::BYTE_W-1:0]  in_stream_byte,
  input  wire logic                         in_first_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [1:0]                   out_event_kind,
  output logic      [fsbd_pkg::VAL_W-1:0]   out_event_value,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fsbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [fsbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [fsbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  logic [fsbd_pkg::TS_W-1:0] time_scale;
  logic                      evt_valid;
  logic                      evt_ready;
  fsbd_pkg::evt_t            evt;

  fsbd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .time_scale (time_scale)
  );

  fsbd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .in_first_byte  (in_first_byte),
    .evt_valid      (evt_valid),
    .evt_ready      (evt_ready),
    .evt            (evt)
  );

  fsbd_scaler u_scaler (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_valid       (evt_valid),
    .evt_ready       (evt_ready),
    .evt             (evt),
    .time_scale      (time_scale),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_event_value (out_event_value)
  );

`ifndef SYNTH
  // an empty result register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == fsbd_pkg::KIND_END |-> out_event_value == '0)
    else $error("end of stream beat with nonzero value");

  // unity scale passes the cell sum through unchanged
  a_unity_scale: assert property (@(posedge clk) disable iff (!rst_n)
    evt_valid && evt_ready && evt.kind == fsbd_pkg::KIND_CELL
    && time_scale == fsbd_pkg::TIME_SCALE_RESET && !evt.val[fsbd_pkg::VAL_W]
    |=> out_event_value == $past(evt.val[fsbd_pkg::VAL_W-1:0]))
    else $error("unity scale changed the cell value");
`endif

endmodule
`default_nettype wire

@@ hdl/fsbd_cfg.sv @@
// apb register block holding the time scale
`default_nettype none
module fsbd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fsbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [fsbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [fsbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [fsbd_pkg::TS_W-1:0]    time_scale
);

  logic [fsbd_pkg::TS_W-1:0] time_scale_r;
  logic [fsbd_pkg::TS_W-1:0] time_scale_nxt;
  logic                      sel_ts;

  assign sel_ts = (paddr[fsbd_pkg::ADDR_W-1] == fsbd_pkg::REG_TIME_SCALE);

  always_comb begin
    time_scale_nxt = time_scale_r;
    if (psel && penable && pwrite && sel_ts) begin
      time_scale_nxt = pwdata[fsbd_pkg::TS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_scale_r <= fsbd_pkg::TIME_SCALE_RESET;
    end else begin
      time_scale_r <= time_scale_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_ts) begin
      prdata = {{(fsbd_pkg::DATA_W - fsbd_pkg::TS_W){1'b0}}, time_scale_r};
    end
  end

  assign pready     = 1'b1;
  assign time_scale = time_scale_r;

endmodule
`default_nettype wire

@@ hdl/fsbd_parser.sv @@
// opcode parser with its state and the decoded event register
`default_nettype none
module fsbd_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fsbd_pkg::BYTE_W-1:0]  in_stream_byte,
  input  wire logic                         in_first_byte,
  output logic                              evt_valid,
  input  wire logic                         evt_ready,
  output fsbd_pkg::evt_t                    evt
);

  fsbd_pkg::phase_t              phase_r, phase_nxt, ph;
  logic [fsbd_pkg::BYTE_W-1:0]   high_r, high_nxt, hb;
  logic [fsbd_pkg::VAL_W-1:0]    ovfl_r, ovfl_nxt, ov;
  logic [fsbd_pkg::SKIP_W-1:0]   skip_r, skip_nxt, sk;
  logic [fsbd_pkg::BYTE_W-1:0]   btype_r, btype_nxt, bt;
  logic [fsbd_pkg::VAL_W-1:0]    pos_r, pos_nxt, pos;
  logic                          fin_r, fin_nxt, fin;
  logic                          emit;
  fsbd_pkg::evt_t                evt_d;
  logic                          evt_valid_r;
  fsbd_pkg::evt_t                evt_r;
  logic                          accept;
  logic [fsbd_pkg::SUM_W-1:0]    ovfl_add;
  logic [fsbd_pkg::SKIP_W-1:0]   skip_dec;
  logic [fsbd_pkg::SKIP_W-1:0]   size_full;
  logic [fsbd_pkg::VAL_W-1:0]    pos_merge;
  logic [fsbd_pkg::BYTE_W-1:0]   b;

  assign b        = in_stream_byte;
  assign in_ready = !evt_valid_r || evt_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // a first byte clears the parser before decoding
    ph  = in_first_byte ? fsbd_pkg::PH_IDLE : phase_r;
    hb  = in_first_byte ? '0 : high_r;
    ov  = in_first_byte ? '0 : ovfl_r;
    sk  = in_first_byte ? '0 : skip_r;
    bt  = in_first_byte ? '0 : btype_r;
    pos = in_first_byte ? '0 : pos_r;
    fin = in_first_byte ? 1'b0 : fin_r;

    ovfl_add  = {1'b0, ov} + {1'b0, fsbd_pkg::OVFL_STEP};
    skip_dec  = sk - fsbd_pkg::SKIP_W'(1);
    size_full = {b, sk[fsbd_pkg::BYTE_W-1:0]};
    pos_merge = pos | ({{(fsbd_pkg::VAL_W - fsbd_pkg::BYTE_W){1'b0}}, b}
                       << {ph[1:0], 3'b000});

    phase_nxt = ph;
    high_nxt  = hb;
    ovfl_nxt  = ov;
    skip_nxt  = sk;
    btype_nxt = bt;
    pos_nxt   = pos;
    fin_nxt   = fin;
    emit      = 1'b0;
    evt_d.kind = fsbd_pkg::KIND_CELL;
    evt_d.val  = {1'b0, ov} + {{(fsbd_pkg::SUM_W - fsbd_pkg::BYTE_W){1'b0}}, b};

    if (!fin) begin
      unique case (ph)
        fsbd_pkg::PH_IDLE: begin
          if (b <= fsbd_pkg::OP_CELL2_MAX) begin
            high_nxt  = b;
            phase_nxt = fsbd_pkg::PH_C2_LO;
          end else if (b <= fsbd_pkg::OP_SKIP_MAX) begin
            skip_nxt = {{(fsbd_pkg::SKIP_W - fsbd_pkg::BYTE_W){1'b0}},
                        b - fsbd_pkg::OP_SKIP_BASE};
            if (b != fsbd_pkg::OP_SKIP_BASE) begin
              phase_nxt = fsbd_pkg::PH_SKIP;
            end
          end else if (b == fsbd_pkg::OP_OVFL) begin
            ovfl_nxt = ovfl_add[fsbd_pkg::SUM_W-1] ? '1 : ovfl_add[fsbd_pkg::VAL_W-1:0];
          end else if (b == fsbd_pkg::OP_CELL3) begin
            phase_nxt = fsbd_pkg::PH_C3_HI;
          end else if (b == fsbd_pkg::OP_OOB) begin
            phase_nxt = fsbd_pkg::PH_OOB_TYPE;
          end else begin
            emit     = 1'b1;
            ovfl_nxt = '0;
          end
        end
        fsbd_pkg::PH_C2_LO, fsbd_pkg::PH_C3_LO: begin
          phase_nxt = fsbd_pkg::PH_IDLE;
          emit      = 1'b1;
          ovfl_nxt  = '0;
          evt_d.val = {1'b0, ov}
                    + {{(fsbd_pkg::SUM_W - 2*fsbd_pkg::BYTE_W){1'b0}}, hb, b};
        end
        fsbd_pkg::PH_C3_HI: begin
          high_nxt  = b;
          phase_nxt = fsbd_pkg::PH_C3_LO;
        end
        fsbd_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = fsbd_pkg::PH_IDLE;
          end
        end
        fsbd_pkg::PH_OOB_TYPE: begin
          btype_nxt = b;
          if (b == fsbd_pkg::TYPE_END) begin
            fin_nxt    = 1'b1;
            phase_nxt  = fsbd_pkg::PH_IDLE;
            emit       = 1'b1;
            evt_d.kind = fsbd_pkg::KIND_END;
            evt_d.val  = '0;
          end else begin
            phase_nxt = fsbd_pkg::PH_SIZE_LO;
          end
        end
        fsbd_pkg::PH_SIZE_LO: begin
          skip_nxt  = {{(fsbd_pkg::SKIP_W - fsbd_pkg::BYTE_W){1'b0}}, b};
          phase_nxt = fsbd_pkg::PH_SIZE_HI;
        end
        fsbd_pkg::PH_SIZE_HI: begin
          skip_nxt = size_full;
          pos_nxt  = '0;
          if (size_full == '0) begin
            phase_nxt = fsbd_pkg::PH_IDLE;
            if (bt == fsbd_pkg::TYPE_INDEX) begin
              emit       = 1'b1;
              evt_d.kind = fsbd_pkg::KIND_INDEX;
              evt_d.val  = '0;
            end
          end else if (bt == fsbd_pkg::TYPE_INDEX) begin
            phase_nxt = fsbd_pkg::PH_PAY0;
          end else begin
            phase_nxt = fsbd_pkg::PH_PAYREST;
          end
        end
        default: begin
          // block payload: index position bytes, then skipped bytes
          skip_nxt  = skip_dec;
          phase_nxt = fsbd_pkg::PH_PAYREST;
          if (bt == fsbd_pkg::TYPE_INDEX && ph >= fsbd_pkg::PH_PAY0
              && ph < fsbd_pkg::PH_PAYREST) begin
            pos_nxt = pos_merge;
            if (ph == fsbd_pkg::PH_PAY3 || skip_dec == '0) begin
              emit       = 1'b1;
              evt_d.kind = fsbd_pkg::KIND_INDEX;
              evt_d.val  = {1'b0, pos_merge};
            end else begin
              phase_nxt = fsbd_pkg::phase_t'(ph + 4'd1);
            end
          end
          if (skip_dec == '0) begin
            phase_nxt = fsbd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fsbd_pkg::PH_IDLE;
      high_r      <= '0;
      ovfl_r      <= '0;
      skip_r      <= '0;
      btype_r     <= '0;
      pos_r       <= '0;
      fin_r       <= 1'b0;
      evt_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        high_r  <= high_nxt;
        ovfl_r  <= ovfl_nxt;
        skip_r  <= skip_nxt;
        btype_r <= btype_nxt;
        pos_r   <= pos_nxt;
        fin_r   <= fin_nxt;
      end
      if (accept) begin
        evt_valid_r <= emit;
      end else if (evt_ready) begin
        evt_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      evt_r <= evt_d;
    end
  end

  assign evt_valid = evt_valid_r;
  assign evt       = evt_r;

endmodule
`default_nettype wire

@@ hdl/fsbd_scaler.sv @@
// cell time scaling, saturation and result register
`default_nettype none
module fsbd_scaler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         evt_valid,
  output logic                              evt_ready,
  input  wire fsbd_pkg::evt_t               evt,
  input  wire logic [fsbd_pkg::TS_W-1:0]    time_scale,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [1:0]                   out_event_kind,
  output logic      [fsbd_pkg::VAL_W-1:0]   out_event_value
);

  logic [fsbd_pkg::PROD_W-1:0] prod;
  logic [fsbd_pkg::VAL_W-1:0]  value_nxt;
  logic                        out_valid_r;
  logic [1:0]                  kind_r;
  logic [fsbd_pkg::VAL_W-1:0]  value_r;
  logic                        load;

  assign evt_ready = !out_valid_r || out_ready;
  assign load      = evt_valid && evt_ready;

  always_comb begin
    prod = {{fsbd_pkg::TS_W{1'b0}}, evt.val}
         * {{fsbd_pkg::SUM_W{1'b0}}, time_scale};
    value_nxt = evt.val[fsbd_pkg::VAL_W-1:0];
    if (evt.kind == fsbd_pkg::KIND_CELL) begin
      if (prod[fsbd_pkg::PROD_W-1:fsbd_pkg::VAL_W+fsbd_pkg::FRAC_W] != '0) begin
        value_nxt = '1;
      end else begin
        value_nxt = prod[fsbd_pkg::VAL_W+fsbd_pkg::FRAC_W-1:fsbd_pkg::FRAC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= evt.kind;
      value_r <= value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_event_value = value_r;

endmodule
`default_nettype wire
